// ----- hdl/odt_pkg.sv -----
// Shared types, codes and threshold tables for the ordered dither threshold block.
`timescale 1ns / 1ps

package odt_pkg;

  localparam int unsigned PIX_W        = 8;
  localparam int unsigned MODE_W       = 3;
  localparam int unsigned LINE_W       = 13;
  localparam int unsigned CFG_IDX_W    = 2;
  localparam int unsigned CFG_DATA_W   = 13;
  localparam int unsigned MAX_LINE_WIDTH_DEF = 4096;
  localparam int unsigned MATRIX_MAX   = 8;
  localparam int unsigned ROW_W        = $clog2(MATRIX_MAX);
  localparam int unsigned QUEUE_DEPTH  = 2;

  localparam logic [PIX_W-1:0] LEVEL_BLACK = 8'd0;
  localparam logic [PIX_W-1:0] LEVEL_1     = 8'd85;
  localparam logic [PIX_W-1:0] LEVEL_2     = 8'd170;
  localparam logic [PIX_W-1:0] LEVEL_WHITE = 8'd255;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_MODE       = 2'd0,
    REG_LINE_WIDTH = 2'd1,
    REG_FIXED_THR  = 2'd2
  } odt_reg_e;

  typedef enum logic [MODE_W-1:0] {
    MODE_FIXED = 3'd0,
    MODE_2X2   = 3'd1,
    MODE_4X4   = 3'd2,
    MODE_8X8   = 3'd3,
    MODE_FOUR  = 3'd4
  } odt_mode_e;

  // How the back end resolves an entry
  typedef enum logic [1:0] {
    KIND_FIXED  = 2'd0,
    KIND_MATRIX = 2'd1,
    KIND_FOUR   = 2'd2
  } odt_kind_e;

  typedef struct packed {
    logic [PIX_W-1:0] pixel;
    odt_kind_e        kind;
    logic [PIX_W-1:0] thr_a;  // fixed or primary matrix threshold (4x4 in four-level)
    logic [PIX_W-1:0] thr_b;  // 8x8 threshold, four-level only
  } odt_entry_t;

  localparam logic [1:0] IDX2 [2][2] = '{'{2'd1, 2'd2}, '{2'd3, 2'd0}};

  localparam logic [3:0] IDX4 [4][4] = '{
    '{4'd5,  4'd9,  4'd6,  4'd10},
    '{4'd13, 4'd1,  4'd14, 4'd2},
    '{4'd7,  4'd11, 4'd4,  4'd8},
    '{4'd15, 4'd3,  4'd12, 4'd0}
  };

  localparam logic [5:0] IDX8 [8][8] = '{
    '{6'd21, 6'd37, 6'd25, 6'd41, 6'd22, 6'd38, 6'd26, 6'd42},
    '{6'd53, 6'd5,  6'd57, 6'd9,  6'd54, 6'd6,  6'd58, 6'd10},
    '{6'd29, 6'd45, 6'd17, 6'd33, 6'd30, 6'd46, 6'd18, 6'd34},
    '{6'd61, 6'd13, 6'd49, 6'd1,  6'd62, 6'd14, 6'd50, 6'd2},
    '{6'd23, 6'd39, 6'd27, 6'd43, 6'd20, 6'd36, 6'd24, 6'd40},
    '{6'd55, 6'd7,  6'd59, 6'd11, 6'd52, 6'd4,  6'd56, 6'd8},
    '{6'd31, 6'd47, 6'd19, 6'd35, 6'd28, 6'd44, 6'd16, 6'd32},
    '{6'd63, 6'd15, 6'd51, 6'd3,  6'd60, 6'd12, 6'd48, 6'd0}
  };

  // (2I+1)*255, at most 127*255, fits 15 bits; divisor 2N^2 is a power of two
  function automatic logic [14:0] odd_scaled(input logic [5:0] idx);
    logic [14:0] p;
    p = 15'({idx, 1'b1}) * 15'd255;
    return p;
  endfunction

  function automatic logic [PIX_W-1:0] thr_2x2(input logic r, input logic c);
    logic [14:0] p;
    p = odd_scaled({4'd0, IDX2[r][c]});
    return p[10:3];  // divide by 8
  endfunction

  function automatic logic [PIX_W-1:0] thr_4x4(input logic [1:0] r, input logic [1:0] c);
    logic [14:0] p;
    p = odd_scaled({2'd0, IDX4[r][c]});
    return p[12:5];  // divide by 32
  endfunction

  function automatic logic [PIX_W-1:0] thr_8x8(input logic [2:0] r, input logic [2:0] c);
    logic [14:0] p;
    p = odd_scaled(IDX8[r][c]);
    return p[14:7];  // divide by 128
  endfunction

endpackage

// ----- hdl/ordered_dither_threshold.sv -----
// Ordered dither threshold block: top level with configuration registers.
`timescale 1ns / 1ps

// One grey pixel in, one pixel out, in raster order, one transfer per clock
// sustained while the output is not stalled. The front end tracks column
// (wrapping at the line width, zero read as one and large values clipped to
// MAX_LINE_WIDTH) and row phase mod 8, restarts both on frame_start, and
// looks up the threshold for the current mode from constant tables or the
// fixed threshold register; the back end compares and registers the result.
// An input transfer passes through the two-entry queue and then the output
// register. While streaming the queue holds one entry, so the input stalls
// once it fills, i.e. from the cycle after the first stalled output cycle.
// Mode 0 (and the unused codes 5..7) is a fixed threshold, 1..3 are 2x2, 4x4
// and 8x8 Bayer matrices, 4 gives four levels from the 4x4 and 8x8 decisions.
// Write configuration only while the block is idle.
module ordered_dither_threshold #(
  parameter int unsigned MAX_LINE_WIDTH = odt_pkg::MAX_LINE_WIDTH_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [odt_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [odt_pkg::CFG_DATA_W-1:0]  cfg_wdata_i,
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  logic [odt_pkg::PIX_W-1:0]       pixel_in_i,
  input  logic                            frame_start_i,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output logic [odt_pkg::PIX_W-1:0]       pixel_out_o
);
  import odt_pkg::*;

  logic [MODE_W-1:0] mode_q;
  logic [LINE_W-1:0] line_width_q;
  logic [PIX_W-1:0]  fixed_thr_q;

  logic       push, full, empty, pop;
  odt_entry_t push_entry, pop_entry;
  logic [$clog2(QUEUE_DEPTH+1)-1:0] q_count;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q       <= MODE_FIXED;
      line_width_q <= 13'd512;
      fixed_thr_q  <= 8'd127;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_MODE:       mode_q       <= cfg_wdata_i[MODE_W-1:0];
        REG_LINE_WIDTH: line_width_q <= cfg_wdata_i[LINE_W-1:0];
        REG_FIXED_THR:  fixed_thr_q  <= cfg_wdata_i[PIX_W-1:0];
        default: ;  // unmapped index, write dropped
      endcase
    end
  end

  odt_front #(
    .MAX_LINE_WIDTH(MAX_LINE_WIDTH)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .mode_i       (mode_q),
    .line_width_i (line_width_q),
    .fixed_thr_i  (fixed_thr_q),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .pixel_in_i   (pixel_in_i),
    .frame_start_i(frame_start_i),
    .push_o       (push),
    .entry_o      (push_entry),
    .full_i       (full)
  );

  odt_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .entry_i(push_entry),
    .full_o (full),
    .empty_o(empty),
    .pop_i  (pop),
    .entry_o(pop_entry),
    .count_o(q_count)
  );

  odt_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .empty_i    (empty),
    .entry_i    (pop_entry),
    .pop_o      (pop),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .pixel_out_o(pixel_out_o)
  );

  // An accepted pixel is held somewhere on the next cycle
  a_accept_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> (q_count != '0) || out_valid_o)
    else $error("accepted pixel lost between front and back");

  // Queue occupancy stays within its depth
  a_queue_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_count <= ($bits(q_count))'(QUEUE_DEPTH))
    else $error("queue count beyond depth");

  // Only the four legal grey levels leave the block
  a_out_levels: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (pixel_out_o == LEVEL_BLACK) || (pixel_out_o == LEVEL_1) ||
                    (pixel_out_o == LEVEL_2) || (pixel_out_o == LEVEL_WHITE))
    else $error("output pixel not a legal level");

endmodule

// ----- hdl/odt_front.sv -----
// Front end: accepts pixels, tracks raster position and looks up thresholds.
`timescale 1ns / 1ps

module odt_front #(
  parameter int unsigned MAX_LINE_WIDTH = odt_pkg::MAX_LINE_WIDTH_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic [odt_pkg::MODE_W-1:0]  mode_i,
  input  logic [odt_pkg::LINE_W-1:0]  line_width_i,
  input  logic [odt_pkg::PIX_W-1:0]   fixed_thr_i,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic [odt_pkg::PIX_W-1:0]   pixel_in_i,
  input  logic                        frame_start_i,
  output logic                        push_o,
  output odt_pkg::odt_entry_t         entry_o,
  input  logic                        full_i
);
  import odt_pkg::*;

  localparam int unsigned CW = $clog2(MAX_LINE_WIDTH);
  localparam int unsigned WW = (CW + 1 > LINE_W) ? CW + 1 : LINE_W;

  logic [CW-1:0]    col_q, col_d, col_cur;
  logic [ROW_W-1:0] row_q, row_d, row_cur;
  logic [WW-1:0]    lw_ext, lw_sat;
  logic [CW:0]      eff_w, col_inc;
  logic             accept;

  assign in_stall_o = full_i;
  assign accept     = in_valid_i && !full_i;
  assign push_o     = accept;

  // Effective width: zero reads as one, large values clip to the maximum
  always_comb begin
    lw_ext = WW'(line_width_i);
    if (lw_ext > WW'(MAX_LINE_WIDTH)) begin
      lw_sat = WW'(MAX_LINE_WIDTH);
    end else if (lw_ext == '0) begin
      lw_sat = WW'(1);
    end else begin
      lw_sat = lw_ext;
    end
    eff_w = lw_sat[CW:0];
  end

  always_comb begin
    col_cur = frame_start_i ? '0 : col_q;
    row_cur = frame_start_i ? '0 : row_q;
    col_inc = {1'b0, col_cur} + (CW+1)'(1);
    if (col_inc >= eff_w) begin
      col_d = '0;
      row_d = row_cur + ROW_W'(1);
    end else begin
      col_d = col_inc[CW-1:0];
      row_d = row_cur;
    end
  end

  always_comb begin
    entry_o.pixel = pixel_in_i;
    entry_o.thr_b = thr_8x8(row_cur, col_cur[ROW_W-1:0]);
    unique case (mode_i)
      MODE_2X2: begin
        entry_o.kind  = KIND_MATRIX;
        entry_o.thr_a = thr_2x2(row_cur[0], col_cur[0]);
      end
      MODE_4X4: begin
        entry_o.kind  = KIND_MATRIX;
        entry_o.thr_a = thr_4x4(row_cur[1:0], col_cur[1:0]);
      end
      MODE_8X8: begin
        entry_o.kind  = KIND_MATRIX;
        entry_o.thr_a = thr_8x8(row_cur, col_cur[ROW_W-1:0]);
      end
      MODE_FOUR: begin
        entry_o.kind  = KIND_FOUR;
        entry_o.thr_a = thr_4x4(row_cur[1:0], col_cur[1:0]);
      end
      default: begin
        entry_o.kind  = KIND_FIXED;
        entry_o.thr_a = fixed_thr_i;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
    end else if (accept) begin
      col_q <= col_d;
      row_q <= row_d;
    end
  end

endmodule

// ----- hdl/odt_queue.sv -----
// Short queue between the front and back ends.
`timescale 1ns / 1ps

module odt_queue (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  input  odt_pkg::odt_entry_t entry_i,
  output logic                full_o,
  output logic                empty_o,
  input  logic                pop_i,
  output odt_pkg::odt_entry_t entry_o,
  output logic [$clog2(odt_pkg::QUEUE_DEPTH+1)-1:0] count_o
);
  import odt_pkg::*;

  localparam int unsigned PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned NW = $clog2(QUEUE_DEPTH + 1);

  odt_entry_t     mem_q [QUEUE_DEPTH];
  logic [PW-1:0]  wr_q, rd_q;
  logic [NW-1:0]  cnt_q, cnt_d;
  logic           do_push, do_pop;

  assign full_o  = (cnt_q == NW'(QUEUE_DEPTH));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign entry_o = mem_q[rd_q];
  assign count_o = cnt_q;

  always_comb begin
    cnt_d = cnt_q;
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + NW'(1);
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - NW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
      if (do_push) begin
        wr_q <= (wr_q == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_q + PW'(1);
      end
      if (do_pop) begin
        rd_q <= (rd_q == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_q + PW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= entry_i;
    end
  end

endmodule

// ----- hdl/odt_back.sv -----
// Back end: threshold compare and registered output stage.
`timescale 1ns / 1ps

module odt_back (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      empty_i,
  input  odt_pkg::odt_entry_t       entry_i,
  output logic                      pop_o,
  output logic                      out_valid_o,
  input  logic                      out_stall_i,
  output logic [odt_pkg::PIX_W-1:0] pixel_out_o
);
  import odt_pkg::*;

  logic             out_valid_q;
  logic [PIX_W-1:0] pix_q, pix_d;
  logic             load, hi_a, hi_b;

  assign load        = !empty_i && (!out_valid_q || !out_stall_i);
  assign pop_o       = load;
  assign out_valid_o = out_valid_q;
  assign pixel_out_o = pix_q;

  always_comb begin
    hi_a = entry_i.pixel > entry_i.thr_a;
    hi_b = entry_i.pixel > entry_i.thr_b;
    case (entry_i.kind)
      KIND_MATRIX: pix_d = hi_a ? LEVEL_WHITE : LEVEL_BLACK;
      KIND_FOUR: begin
        case ({hi_a, hi_b})
          2'b00:   pix_d = LEVEL_BLACK;
          2'b01:   pix_d = LEVEL_1;
          2'b10:   pix_d = LEVEL_2;
          default: pix_d = LEVEL_WHITE;
        endcase
      end
      // fixed threshold: strictly below gives black
      default: pix_d = (entry_i.pixel < entry_i.thr_a) ? LEVEL_BLACK : LEVEL_WHITE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (load) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      pix_q <= pix_d;
    end
  end

endmodule
